@@ rtl/assert_macros.svh @@
// Assertion macros shared by the scanner RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/mss_pkg.sv @@
// Shared types, constants and segment decode for the seven-segment scanner
`timescale 1ns / 1ps
package mss_pkg;
	localparam int unsigned DIGITS = 10;
	localparam int unsigned STEP_W = 4;
	localparam int unsigned BIT_W = 5;
	localparam int unsigned CODE_W = 4;
	localparam int unsigned DWELL_W = 16;
	localparam int unsigned SelShift = 6;
	localparam int unsigned LastBit = 23;
	localparam int unsigned SegBase = 16;
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic [CODE_W-1:0] CODE_BLANK = 4'd11;

	localparam logic REG_DWELL = 1'b0;
	localparam logic REG_POINT = 1'b1;

	typedef struct packed {
		logic [DWELL_W-1:0] dwell_ticks;
		logic [DIGITS-1:0] point_mask;
	} mss_cfg_t;

	// active-low segment byte, bit 0 is the decimal point
	function automatic logic [7:0] seg_byte(input logic [CODE_W-1:0] code);
		logic [7:0] s;
		case (code)
			4'd0: s = 8'h03;
			4'd1: s = 8'h9F;
			4'd2: s = 8'h25;
			4'd3: s = 8'h0D;
			4'd4: s = 8'h99;
			4'd5: s = 8'h49;
			4'd6: s = 8'h41;
			4'd7: s = 8'h1F;
			4'd8: s = 8'h01;
			4'd9: s = 8'h09;
			4'd10: s = 8'hFD;
			4'd12: s = 8'h71;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction
endpackage

@@ rtl/multiplexed_seven_segment_scanner.sv @@
// Top level: digit store, pin-level scan sequencer and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Scans a ten-digit common-anode display through a serial latch chain. Each input
// beat is a load (func=1, writes one 4-bit digit code, no output beat) or a tick
// (func=0, one output beat of pin levels). For every beat, the state
// update and the next pin levels are formed in a single pass into the output
// register, and a new beat is taken each cycle while that register is empty or
// being drained. Per scan step the pins shift 24 bits (16 select, then 8 segment,
// LSB first) at two ticks per bit, give one latch tick, then dwell_ticks ticks.
module multiplexed_seven_segment_scanner
	import mss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [3:0]        digit_index,
	input  logic [3:0]        digit_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              shift_clock,
	output logic              shift_data,
	output logic              latch_clock,
	output logic [3:0]        scan_digit,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	typedef enum logic [1:0] {
		PH_SETUP = 2'd0,
		PH_RISE  = 2'd1,
		PH_LATCH = 2'd2,
		PH_DWELL = 2'd3
	} phase_t;

	mss_cfg_t cfg;

	logic [CODE_W-1:0] digit_store_q [DIGITS];
	logic [STEP_W-1:0] scan_step_q;
	logic [BIT_W-1:0] bit_pos_q;
	phase_t phase_q;
	logic [DWELL_W-1:0] dwell_cnt_q;

	logic out_valid_q;
	logic shift_clock_q;
	logic shift_data_q;
	logic latch_clock_q;
	logic [STEP_W-1:0] scan_digit_q;

	logic in_acc;
	logic tick_acc;
	logic [STEP_W-1:0] k;
	logic [STEP_W-1:0] d;
	logic [BIT_W-1:0] bp;
	logic [7:0] seg;
	logic bit_val;
	logic top_bit;
	logic [DWELL_W-1:0] dwell_inc;
	logic [STEP_W-1:0] k_next;

	mss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc = in_valid && in_ready;
	assign tick_acc = in_acc && !func;

	always_comb begin
		k = (scan_step_q >= STEP_W'(DIGITS)) ? '0 : scan_step_q;
		d = STEP_W'(DIGITS - 1) - k;
		bp = (bit_pos_q > BIT_W'(LastBit)) ? BIT_W'(LastBit) : bit_pos_q;
		seg = seg_byte(digit_store_q[d]);
		if (cfg.point_mask[d])
			seg[0] = 1'b0;
		if (bp < BIT_W'(SegBase))
			bit_val = (bp == BIT_W'(k) + BIT_W'(SelShift));
		else
			bit_val = seg[bp[2:0]];
		top_bit = seg[7];
		dwell_inc = dwell_cnt_q + DWELL_W'(1);
		k_next = (k + STEP_W'(1) >= STEP_W'(DIGITS)) ? '0 : k + STEP_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++)
				digit_store_q[i] <= CODE_BLANK;
		end else if (in_acc && func && digit_index < 4'(DIGITS)) begin
			digit_store_q[digit_index] <= digit_code;
		end
	end

	// scan sequencer and output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_step_q <= '0;
			bit_pos_q <= '0;
			phase_q <= PH_SETUP;
			dwell_cnt_q <= '0;
			out_valid_q <= 1'b0;
			shift_clock_q <= 1'b0;
			shift_data_q <= 1'b0;
			latch_clock_q <= 1'b0;
			scan_digit_q <= '0;
		end else begin
			if (tick_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (tick_acc) begin
				scan_digit_q <= k;
				case (phase_q)
					PH_SETUP: begin
						shift_clock_q <= 1'b0;
						shift_data_q <= bit_val;
						latch_clock_q <= 1'b0;
						scan_step_q <= k;
						bit_pos_q <= bp;
						phase_q <= PH_RISE;
					end
					PH_RISE: begin
						shift_clock_q <= 1'b1;
						shift_data_q <= bit_val;
						latch_clock_q <= 1'b0;
						scan_step_q <= k;
						if (bp == BIT_W'(LastBit)) begin
							bit_pos_q <= '0;
							phase_q <= PH_LATCH;
						end else begin
							bit_pos_q <= bp + BIT_W'(1);
							phase_q <= PH_SETUP;
						end
					end
					PH_LATCH: begin
						shift_clock_q <= 1'b1;
						shift_data_q <= top_bit;
						latch_clock_q <= 1'b1;
						dwell_cnt_q <= '0;
						if (cfg.dwell_ticks == '0) begin
							scan_step_q <= k_next;
							bit_pos_q <= '0;
							phase_q <= PH_SETUP;
						end else begin
							scan_step_q <= k;
							phase_q <= PH_DWELL;
						end
					end
					default: begin
						shift_clock_q <= 1'b1;
						shift_data_q <= top_bit;
						latch_clock_q <= 1'b0;
						if (dwell_inc >= cfg.dwell_ticks || dwell_inc == '0) begin
							scan_step_q <= k_next;
							bit_pos_q <= '0;
							phase_q <= PH_SETUP;
							dwell_cnt_q <= '0;
						end else begin
							scan_step_q <= k;
							dwell_cnt_q <= dwell_inc;
						end
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign shift_clock = shift_clock_q;
	assign shift_data = shift_data_q;
	assign latch_clock = latch_clock_q;
	assign scan_digit = scan_digit_q;

	`ASSERT_ALWAYS(a_step_range, clk, arst_n, scan_step_q < STEP_W'(DIGITS),
		"scan step out of range")
	`ASSERT_ALWAYS(a_bit_range, clk, arst_n, bit_pos_q <= BIT_W'(LastBit),
		"bit position past stream end")
	`ASSERT_IMPL(a_latch_clk, clk, arst_n, out_valid && latch_clock, shift_clock,
		"latch pulse with shift clock low")
	`ASSERT_NEXT(a_latch_beat, clk, arst_n, tick_acc && phase_q == PH_LATCH,
		out_valid && latch_clock, "latch tick did not pulse latch")
	`ASSERT_NEXT(a_load_quiet, clk, arst_n, in_acc && func && !out_valid_q, !out_valid,
		"load produced an output beat")
endmodule

@@ rtl/mss_regs.sv @@
// APB configuration registers: dwell length and decimal point mask
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mss_regs
	import mss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output mss_cfg_t          cfg
);
	logic [DWELL_W-1:0] dwell_ticks_q;
	logic [DIGITS-1:0] point_mask_q;
	logic wr_en;
	logic reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= DWELL_W'(1000);
			point_mask_q <= DIGITS'(18);
		end else if (wr_en) begin
			case (reg_sel)
				REG_DWELL: dwell_ticks_q <= pwdata[DWELL_W-1:0];
				REG_POINT: point_mask_q <= pwdata[DIGITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DWELL: prdata = APB_DW'(dwell_ticks_q);
			REG_POINT: prdata = APB_DW'(point_mask_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.dwell_ticks = dwell_ticks_q;
	assign cfg.point_mask = point_mask_q;

	`ASSERT_NEXT(a_dwell_wr, clk, arst_n, wr_en && reg_sel == REG_DWELL, dwell_ticks_q == $past(pwdata[DWELL_W-1:0]), "dwell register write lost")
	`ASSERT_NEXT(a_point_wr, clk, arst_n, wr_en && reg_sel == REG_POINT, point_mask_q == $past(pwdata[DIGITS-1:0]), "point mask write lost")
	`ASSERT_NEXT(a_cfg_hold, clk, arst_n, !wr_en, $stable(cfg), "config changed without a write")
endmodule
